@@ rtl/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants for the blocking channel engine.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CapMax    = 16;
  localparam int unsigned WaitDepth = 16;
  localparam int unsigned RingIdxW  = (CapMax > 1) ? $clog2(CapMax) : 1;
  localparam int unsigned RingCntW  = $clog2(CapMax + 1);
  localparam int unsigned WaitIdxW  = (WaitDepth > 1) ? $clog2(WaitDepth) : 1;
  localparam int unsigned WaitCntW  = $clog2(WaitDepth + 1);
  localparam int unsigned CapW      = 5;

  // Request codes
  localparam logic [1:0] FuncSend  = 2'd0;
  localparam logic [1:0] FuncRecv  = 2'd1;
  localparam logic [1:0] FuncClose = 2'd2;
  localparam logic [1:0] FuncNop   = 2'd3;

  // Result codes
  localparam logic [3:0] KindSent        = 4'd0;
  localparam logic [3:0] KindReceived    = 4'd1;
  localparam logic [3:0] KindBlocked     = 4'd2;
  localparam logic [3:0] KindWakeSendOk  = 4'd3;
  localparam logic [3:0] KindWakePanic   = 4'd4;
  localparam logic [3:0] KindWakeRecv    = 4'd5;
  localparam logic [3:0] KindErrClosed   = 4'd6;
  localparam logic [3:0] KindErrReclose  = 4'd7;
  localparam logic [3:0] KindErrMain     = 4'd8;
  localparam logic [3:0] KindErrFull     = 4'd9;

  typedef struct packed {
    logic [1:0]           func;
    logic [7:0]           task_id;
    logic                 from_task;
    logic [DataWidth-1:0] send_value;
  } req_t;

  typedef struct packed {
    logic [3:0]           kind;
    logic [7:0]           target_id;
    logic [DataWidth-1:0] value;
    logic                 last;
  } rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StSecond,
    StDrain
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic second;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_close;
    logic is_nop;
    logic closed;
    logic has_second;
    logic drain_empty;
  } stat_t;

endpackage

@@ rtl/blocking_channel_engine.sv @@
// ----------------------------------------------------------------------------
// blocking_channel_engine
// Buffered channel with blocking senders and receivers and a close request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_stall    bce_pkg::req_t
//  out      output     out_valid/out_stall  bce_pkg::rsp_t
//  cfg      input      cfg_valid/cfg_ready  capacity, 5 bits
//
//  A request is loaded, then the results it causes are emitted one after
//  another; send and receive give one or two results, close one per waiting
//  task plus one, after it sets the closed flag. The sequencer handles one
//  request at a time. Reset empties buffer and queues; capacity resets to 0.
//  A stalled output holds the sequencer until the result is taken.
// ----------------------------------------------------------------------------
module blocking_channel_engine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  bce_pkg::req_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output bce_pkg::rsp_t            out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bce_pkg::CapW-1:0] cfg_data_i
);

  bce_pkg::cmd_t  cmd;
  bce_pkg::stat_t stat;

  bce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bce_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/bce_ctrl.sv @@
// ----------------------------------------------------------------------------
// bce_ctrl
// Sequencer: accepts a request, runs it, then emits follow-up results.
// ----------------------------------------------------------------------------
module bce_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           cfg_ready_o,
  input  bce_pkg::stat_t stat_i,
  output bce_pkg::cmd_t  cmd_o
);

  bce_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bce_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b0;
    case (state_q)
      bce_pkg::StIdle: begin
        in_stall_o  = 1'b0;
        cfg_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bce_pkg::StExec;
        end
      end
      bce_pkg::StExec: begin
        if (stat_i.is_nop) begin
          state_d = bce_pkg::StIdle;
        end else if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          if (stat_i.is_close) begin
            state_d = stat_i.closed ? bce_pkg::StIdle : bce_pkg::StDrain;
          end else begin
            state_d = stat_i.has_second ? bce_pkg::StSecond : bce_pkg::StIdle;
          end
        end
      end
      bce_pkg::StSecond: begin
        if (stat_i.out_free) begin
          cmd_o.second = 1'b1;
          state_d      = bce_pkg::StIdle;
        end
      end
      bce_pkg::StDrain: begin
        if (stat_i.out_free) begin
          cmd_o.drain = 1'b1;
          if (stat_i.drain_empty) begin
            state_d = bce_pkg::StIdle;
          end
        end
      end
      default: state_d = bce_pkg::StIdle;
    endcase
  end

endmodule

@@ rtl/bce_datapath.sv @@
// ----------------------------------------------------------------------------
// bce_datapath
// Ring buffer, wait queues, closed flag and the result register.
// ----------------------------------------------------------------------------
module bce_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bce_pkg::req_t              in_data_i,
  input  logic                       cfg_we_i,
  input  logic [bce_pkg::CapW-1:0]   cfg_data_i,
  input  bce_pkg::cmd_t              cmd_i,
  output bce_pkg::stat_t             stat_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bce_pkg::rsp_t              out_data_o
);

  localparam int unsigned RIW = bce_pkg::RingIdxW;
  localparam int unsigned RCW = bce_pkg::RingCntW;
  localparam int unsigned WIW = bce_pkg::WaitIdxW;
  localparam int unsigned WCW = bce_pkg::WaitCntW;
  localparam int unsigned DW  = bce_pkg::DataWidth;

  bce_pkg::req_t  req_q;
  logic [DW-1:0]  ring_q [bce_pkg::CapMax];
  logic [7:0]     sid_q  [bce_pkg::WaitDepth];
  logic [DW-1:0]  sval_q [bce_pkg::WaitDepth];
  logic [7:0]     rid_q  [bce_pkg::WaitDepth];

  logic [RCW-1:0] cap_q, cap_d;
  logic [RIW-1:0] rhead_q, rhead_d, rtail_q, rtail_d;
  logic [RCW-1:0] rcnt_q, rcnt_d;
  logic           closed_q, closed_d;
  logic [WIW-1:0] sqh_q, sqh_d, sqt_q, sqt_d, rqh_q, rqh_d, rqt_q, rqt_d;
  logic [WCW-1:0] sqc_q, sqc_d, rqc_q, rqc_d;
  logic [7:0]     sec_id_q, sec_id_d;
  logic           out_valid_q, out_valid_d;
  bce_pkg::rsp_t  out_q, out_d;
  logic           out_free;
  logic           ring_we, sq_we, rq_we;
  logic [DW-1:0]  ring_wdata;

  function automatic logic [RIW-1:0] ring_next(logic [RIW-1:0] i, logic [RCW-1:0] cap);
    logic [RCW:0] n;
    n = {{(RCW+1-RIW){1'b0}}, i} + 1'b1;
    return (n >= {1'b0, cap}) ? '0 : n[RIW-1:0];
  endfunction

  function automatic logic [WIW-1:0] wait_next(logic [WIW-1:0] i);
    logic [WIW:0] n;
    n = {1'b0, i} + 1'b1;
    return (n >= (WIW+1)'(bce_pkg::WaitDepth)) ? '0 : n[WIW-1:0];
  endfunction

  function automatic bce_pkg::rsp_t mk(logic [3:0] k, logic [7:0] id,
                                       logic [DW-1:0] v, logic l);
    bce_pkg::rsp_t r;
    r.kind = k; r.target_id = id; r.value = v; r.last = l;
    return r;
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;

  // Status toward the sequencer
  always_comb begin
    stat_o.out_free    = out_free;
    stat_o.is_close    = (req_q.func == bce_pkg::FuncClose);
    stat_o.is_nop      = (req_q.func != bce_pkg::FuncSend) &&
                         (req_q.func != bce_pkg::FuncRecv) &&
                         (req_q.func != bce_pkg::FuncClose);
    stat_o.closed      = closed_q;
    stat_o.has_second  = ((req_q.func == bce_pkg::FuncSend) && !closed_q && (rqc_q != '0)) ||
                         ((req_q.func == bce_pkg::FuncRecv) && (sqc_q != '0));
    stat_o.drain_empty = (rqc_q == '0) && (sqc_q == '0);
  end

  // Request execution and result selection
  always_comb begin
    cap_d = cap_q; rhead_d = rhead_q; rtail_d = rtail_q; rcnt_d = rcnt_q;
    closed_d = closed_q;
    sqh_d = sqh_q; sqt_d = sqt_q; sqc_d = sqc_q;
    rqh_d = rqh_q; rqt_d = rqt_q; rqc_d = rqc_q;
    sec_id_d = sec_id_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    out_d = out_q;
    ring_we = 1'b0; ring_wdata = req_q.send_value;
    sq_we = 1'b0; rq_we = 1'b0;

    if (cfg_we_i) begin
      cap_d   = (cfg_data_i > RCW'(bce_pkg::CapMax)) ? RCW'(bce_pkg::CapMax)
                                                      : cfg_data_i[RCW-1:0];
      rhead_d = '0; rtail_d = '0; rcnt_d = '0;
    end

    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
      case (req_q.func)
        bce_pkg::FuncSend: begin
          if (closed_q) begin
            out_d = mk(bce_pkg::KindErrClosed, req_q.task_id, '0, 1'b1);
          end else if (rqc_q != '0) begin
            out_d    = mk(bce_pkg::KindWakeRecv, rid_q[rqh_q], req_q.send_value, 1'b0);
            sec_id_d = req_q.task_id;
            rqh_d    = wait_next(rqh_q);
            rqc_d    = rqc_q - 1'b1;
          end else if (rcnt_q < cap_q) begin
            ring_we = 1'b1;
            rtail_d = ring_next(rtail_q, cap_q);
            rcnt_d  = rcnt_q + 1'b1;
            out_d   = mk(bce_pkg::KindSent, req_q.task_id, '0, 1'b1);
          end else if (!req_q.from_task) begin
            out_d = mk(bce_pkg::KindErrMain, req_q.task_id, '0, 1'b1);
          end else if (sqc_q == WCW'(bce_pkg::WaitDepth)) begin
            out_d = mk(bce_pkg::KindErrFull, req_q.task_id, '0, 1'b1);
          end else begin
            sq_we = 1'b1;
            sqt_d = wait_next(sqt_q);
            sqc_d = sqc_q + 1'b1;
            out_d = mk(bce_pkg::KindBlocked, req_q.task_id, '0, 1'b1);
          end
        end
        bce_pkg::FuncRecv: begin
          if (sqc_q != '0) begin
            sec_id_d = sid_q[sqh_q];
            sqh_d    = wait_next(sqh_q);
            sqc_d    = sqc_q - 1'b1;
            if (rcnt_q != '0) begin
              out_d      = mk(bce_pkg::KindReceived, req_q.task_id, ring_q[rhead_q], 1'b0);
              ring_we    = 1'b1;
              ring_wdata = sval_q[sqh_q];
              rhead_d    = ring_next(rhead_q, cap_q);
              rtail_d    = ring_next(rtail_q, cap_q);
            end else begin
              out_d = mk(bce_pkg::KindReceived, req_q.task_id, sval_q[sqh_q], 1'b0);
            end
          end else if (rcnt_q != '0) begin
            out_d   = mk(bce_pkg::KindReceived, req_q.task_id, ring_q[rhead_q], 1'b1);
            rhead_d = ring_next(rhead_q, cap_q);
            rcnt_d  = rcnt_q - 1'b1;
          end else if (closed_q) begin
            out_d = mk(bce_pkg::KindReceived, req_q.task_id, '0, 1'b1);
          end else if (!req_q.from_task) begin
            out_d = mk(bce_pkg::KindErrMain, req_q.task_id, '0, 1'b1);
          end else if (rqc_q == WCW'(bce_pkg::WaitDepth)) begin
            out_d = mk(bce_pkg::KindErrFull, req_q.task_id, '0, 1'b1);
          end else begin
            rq_we = 1'b1;
            rqt_d = wait_next(rqt_q);
            rqc_d = rqc_q + 1'b1;
            out_d = mk(bce_pkg::KindBlocked, req_q.task_id, '0, 1'b1);
          end
        end
        default: begin
          // Close: report a second close, else mark closed and drain next
          if (closed_q) begin
            out_d = mk(bce_pkg::KindErrReclose, req_q.task_id, '0, 1'b1);
          end else begin
            closed_d    = 1'b1;
            out_valid_d = out_free ? 1'b0 : out_valid_q;
          end
        end
      endcase
    end

    // Follow-up result of a rendezvous
    if (cmd_i.second) begin
      out_valid_d = 1'b1;
      out_d = mk((req_q.func == bce_pkg::FuncSend) ? bce_pkg::KindSent
                                                   : bce_pkg::KindWakeSendOk,
                 sec_id_q, '0, 1'b1);
    end

    // Wake one waiter per step, then finish the close
    if (cmd_i.drain) begin
      out_valid_d = 1'b1;
      if (rqc_q != '0) begin
        out_d = mk(bce_pkg::KindWakeRecv, rid_q[rqh_q], '0, 1'b0);
        rqh_d = wait_next(rqh_q);
        rqc_d = rqc_q - 1'b1;
      end else if (sqc_q != '0) begin
        out_d = mk(bce_pkg::KindWakePanic, sid_q[sqh_q], '0, 1'b0);
        sqh_d = wait_next(sqh_q);
        sqc_d = sqc_q - 1'b1;
      end else begin
        out_d = mk(bce_pkg::KindSent, req_q.task_id, '0, 1'b1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0; rhead_q <= '0; rtail_q <= '0; rcnt_q <= '0;
      closed_q <= 1'b0;
      sqh_q <= '0; sqt_q <= '0; sqc_q <= '0;
      rqh_q <= '0; rqt_q <= '0; rqc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q <= cap_d; rhead_q <= rhead_d; rtail_q <= rtail_d; rcnt_q <= rcnt_d;
      closed_q <= closed_d;
      sqh_q <= sqh_d; sqt_q <= sqt_d; sqc_q <= sqc_d;
      rqh_q <= rqh_d; rqt_q <= rqt_d; rqc_q <= rqc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
    sec_id_q <= sec_id_d;
    out_q    <= out_d;
    if (ring_we) ring_q[rtail_q] <= ring_wdata;
    if (sq_we) begin
      sid_q[sqt_q]  <= req_q.task_id;
      sval_q[sqt_q] <= req_q.send_value;
    end
    if (rq_we) rid_q[rqt_q] <= req_q.task_id;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ring_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) rcnt_q <= cap_q)
    else $error("ring count above capacity");
  a_sq_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqc_q <= WCW'(bce_pkg::WaitDepth)) else $error("sender queue overflow");
  a_rq_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rqc_q <= WCW'(bce_pkg::WaitDepth)) else $error("receiver queue overflow");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((sqc_q != '0) && (rqc_q != '0))) else $error("senders and receivers both waiting");

endmodule
